// ===== sv/piecewise_linear_interp_assert.svh =====
// ----------------------------------------------------------------------------
// piecewise_linear_interp_assert.svh
// Assertion macros used by the interpolator top module.
// ----------------------------------------------------------------------------
`ifndef PIECEWISE_LINEAR_INTERP_ASSERT_SVH
`define PIECEWISE_LINEAR_INTERP_ASSERT_SVH

// same-cycle implication
`define PLI_ASSERT_IMP(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// next-cycle implication
`define PLI_ASSERT_NXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== sv/pli_pkg.sv =====
// ----------------------------------------------------------------------------
// pli_pkg
// Shared constants and types of the piecewise linear interpolator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pli_pkg;

  localparam int MAX_POINTS = 16;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = 5;

  localparam int XY_W       = 16;
  localparam int FRAC_W     = 8;
  localparam int Q_W        = XY_W + FRAC_W;

  // divider: numerator magnitude, divisor, quotient, step counter
  localparam int NUM_W      = XY_W + Q_W;
  localparam int DEN_W      = XY_W;
  localparam int QUOT_W     = Q_W;
  localparam int STEP_W     = $clog2(QUOT_W);

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic [XY_W-1:0]         wr_x;
    logic [XY_W-1:0]         wr_y;
    logic                    rd_en;
    logic [IDX_W-1:0]        rd_addr;
  } tbl_req_t;

endpackage

`default_nettype wire

// ===== sv/pli_table.sv =====
// ----------------------------------------------------------------------------
// pli_table
// Breakpoint store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pli_table (
  input  wire logic                          clk,
  input  wire pli_pkg::tbl_req_t             req,
  output logic        [pli_pkg::XY_W-1:0]    rd_x,
  output logic        [pli_pkg::XY_W-1:0]    rd_y
);

  logic [pli_pkg::XY_W-1:0] mem_x [pli_pkg::MAX_POINTS];
  logic [pli_pkg::XY_W-1:0] mem_y [pli_pkg::MAX_POINTS];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_x[req.wr_addr] <= req.wr_x;
      mem_y[req.wr_addr] <= req.wr_y;
    end
    if (req.rd_en) begin
      rd_x <= mem_x[req.rd_addr];
      rd_y <= mem_y[req.rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/pli_div.sv =====
// ----------------------------------------------------------------------------
// pli_div
// Restoring divider, one quotient bit per cycle. The numerator's upper part
// must be below the divisor, so only QUOT_W steps are needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pli_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [pli_pkg::NUM_W-1:0]     num,
  input  wire logic [pli_pkg::DEN_W-1:0]     den,
  output logic                               done,
  output logic      [pli_pkg::QUOT_W-1:0]    quot
);

  logic [pli_pkg::DEN_W-1:0]   rem;
  logic [pli_pkg::QUOT_W-1:0]  shreg;
  logic [pli_pkg::STEP_W-1:0]  step;
  logic                        run;

  logic [pli_pkg::DEN_W:0]     trial;
  logic [pli_pkg::DEN_W+1:0]   diff;
  logic                        ge;

  assign trial = {rem, shreg[pli_pkg::QUOT_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, den};
  assign ge    = ~diff[pli_pkg::DEN_W+1];
  assign quot  = shreg;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem   <= num[pli_pkg::NUM_W-1:pli_pkg::QUOT_W];
        shreg <= num[pli_pkg::QUOT_W-1:0];
        step  <= pli_pkg::STEP_W'(pli_pkg::QUOT_W - 1);
        run   <= 1'b1;
      end else if (run) begin
        rem   <= ge ? diff[pli_pkg::DEN_W-1:0] : trial[pli_pkg::DEN_W-1:0];
        shreg <= {shreg[pli_pkg::QUOT_W-2:0], ge};
        if (step == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/piecewise_linear_interp.sv =====
// ----------------------------------------------------------------------------
// piecewise_linear_interp
// Breakpoint table with segment search and linear interpolation in Q16.8.
// ----------------------------------------------------------------------------
// A load transfer writes one breakpoint and gives no result. A query
// transfer scans the table one entry per cycle through the single read
// port, multiplies once and then runs a 24-step restoring divider: a query
// that hits a segment offers its interpolated result, while a miss over the
// points in use (point_count capped at 16), or fewer than two points,
// offers zero with hit low. The input is stalled while a query is in
// flight and while its finished result waits for a blocked output register;
// once the result sits in the output register the next transfer is accepted.
// point_count is set over the APB port at address 0 and must only be written
// while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "piecewise_linear_interp_assert.svh"

module piecewise_linear_interp (
  input  wire logic               clk,
  input  wire logic               rst,

  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [1:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,

  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               kind,
  input  wire logic [3:0]         load_index,
  input  wire logic signed [15:0] load_x,
  input  wire logic signed [15:0] load_y,
  input  wire logic signed [23:0] speed,

  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [23:0]      accel,
  output logic                    hit
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRIME,
    ST_SCAN,
    ST_MUL,
    ST_DIVS,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t state;

  logic [pli_pkg::CNT_W-1:0]        point_count;
  logic [pli_pkg::CNT_W-1:0]        n_eff;
  logic [pli_pkg::CNT_W-1:0]        n_last;

  logic signed [pli_pkg::Q_W-1:0]   query_speed;
  logic [pli_pkg::IDX_W-1:0]        idx;
  logic [pli_pkg::IDX_W-1:0]        last_idx;
  logic signed [pli_pkg::XY_W-1:0]  x0;
  logic signed [pli_pkg::XY_W-1:0]  y0;
  logic signed [pli_pkg::XY_W:0]    dy;
  logic [pli_pkg::DEN_W-1:0]        dx;
  logic [pli_pkg::Q_W-1:0]          off;
  logic signed [pli_pkg::XY_W+pli_pkg::Q_W+1:0] prod;
  logic [pli_pkg::XY_W+pli_pkg::Q_W+1:0]        prod_abs;
  logic signed [pli_pkg::Q_W-1:0]   acc;
  logic                             acc_hit;

  pli_pkg::tbl_req_t                tbl_req;
  logic [pli_pkg::XY_W-1:0]         rd_x;
  logic [pli_pkg::XY_W-1:0]         rd_y;

  logic                             div_start;
  logic                             div_done;
  logic [pli_pkg::QUOT_W-1:0]       quot;

  logic                             in_acc;
  logic                             cfg_wr;
  logic                             out_free;
  logic signed [pli_pkg::Q_W-1:0]   x0_q;
  logic signed [pli_pkg::Q_W-1:0]   x1_q;
  logic                             seg_hit;
  logic [pli_pkg::Q_W:0]            diff_off;
  logic [pli_pkg::Q_W:0]            q_signed;
  logic [pli_pkg::Q_W:0]            sum;

  // APB
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == 2'd0);
  assign prdata = (paddr == 2'd0) ? {{(32-pli_pkg::CNT_W){1'b0}}, point_count} : 32'd0;

  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign n_eff  = (point_count > pli_pkg::CNT_W'(pli_pkg::MAX_POINTS))
                  ? pli_pkg::CNT_W'(pli_pkg::MAX_POINTS) : point_count;
  assign n_last = n_eff - 1'b1;

  assign x0_q    = $signed({x0, {pli_pkg::FRAC_W{1'b0}}});
  assign x1_q    = $signed({rd_x, {pli_pkg::FRAC_W{1'b0}}});
  assign seg_hit = (query_speed >= x0_q) && (query_speed < x1_q);
  assign diff_off = {query_speed[pli_pkg::Q_W-1], query_speed} - {x0_q[pli_pkg::Q_W-1], x0_q};

  assign prod_abs  = prod[$bits(prod)-1] ? $bits(prod)'(-prod) : prod;
  assign div_start = (state == ST_DIVS);
  assign q_signed  = prod[$bits(prod)-1] ? (pli_pkg::Q_W+1)'(-{1'b0, quot}) : {1'b0, quot};
  assign sum       = {y0[pli_pkg::XY_W-1], y0, {pli_pkg::FRAC_W{1'b0}}} + q_signed;

  always_comb begin
    tbl_req.wr_en   = in_acc && (kind == pli_pkg::KIND_LOAD)
                      && ({1'b0, load_index} < (pli_pkg::IDX_W+1)'(pli_pkg::MAX_POINTS));
    tbl_req.wr_addr = load_index[pli_pkg::IDX_W-1:0];
    tbl_req.wr_x    = load_x;
    tbl_req.wr_y    = load_y;
    tbl_req.rd_en   = (in_acc && (kind == pli_pkg::KIND_QUERY))
                      || (state == ST_PRIME) || (state == ST_SCAN);
    case (state)
      ST_PRIME: tbl_req.rd_addr = idx;
      ST_SCAN:  tbl_req.rd_addr = idx + 1'b1;
      default:  tbl_req.rd_addr = '0;
    endcase
  end

  pli_table u_table (
    .clk  (clk),
    .req  (tbl_req),
    .rd_x (rd_x),
    .rd_y (rd_y)
  );

  pli_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (prod_abs[pli_pkg::NUM_W-1:0]),
    .den   (dx),
    .done  (div_done),
    .quot  (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
    end else if (cfg_wr) begin
      point_count <= pwdata[pli_pkg::CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if ((state == ST_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc && (kind == pli_pkg::KIND_QUERY)) begin
            query_speed <= speed;
            last_idx    <= n_last[pli_pkg::IDX_W-1:0];
            idx         <= pli_pkg::IDX_W'(1);
            if (n_eff < pli_pkg::CNT_W'(2)) begin
              acc     <= '0;
              acc_hit <= 1'b0;
              state   <= ST_DONE;
            end else begin
              state   <= ST_PRIME;
            end
          end
        end
        ST_PRIME: begin
          x0    <= $signed(rd_x);
          y0    <= $signed(rd_y);
          state <= ST_SCAN;
        end
        ST_SCAN: begin
          if (seg_hit) begin
            dy    <= $signed({rd_y[pli_pkg::XY_W-1], rd_y}) - $signed({y0[pli_pkg::XY_W-1], y0});
            dx    <= rd_x - x0;
            off   <= diff_off[pli_pkg::Q_W-1:0];
            state <= ST_MUL;
          end else if (idx == last_idx) begin
            acc     <= '0;
            acc_hit <= 1'b0;
            state   <= ST_DONE;
          end else begin
            x0  <= $signed(rd_x);
            y0  <= $signed(rd_y);
            idx <= idx + 1'b1;
          end
        end
        ST_MUL: begin
          prod  <= dy * $signed({1'b0, off});
          state <= ST_DIVS;
        end
        ST_DIVS: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            acc     <= $signed(sum[pli_pkg::Q_W-1:0]);
            acc_hit <= 1'b1;
            state   <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            accel     <= acc;
            hit       <= acc_hit;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `PLI_ASSERT_IMP(a_miss_is_zero, out_valid && !hit, accel == '0, "miss result not zero")
  `PLI_ASSERT_IMP(a_div_done_state, div_done, state == ST_DIV, "divider done outside wait")
  `PLI_ASSERT_IMP(a_scan_bound, state == ST_SCAN, idx <= last_idx, "scan ran past last point")
  `PLI_ASSERT_NXT(a_query_busy, in_acc && (kind == pli_pkg::KIND_QUERY), in_stall,
                  "query accepted without going busy")

endmodule

`default_nettype wire
